[rtl/core/hhcr_pkg.sv]
// ----------------------------------------------------------------------------
// hhcr_pkg: shared types and helpers for the hex header CRC frame receiver
// Frame layout constants, status codes, result word layout, hex digit decode
// and the byte-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
`default_nettype none

package hhcr_pkg;

  localparam int HEADER_BYTES  = 10;
  localparam int TRAILER_BYTES = 8;
  localparam int SEQ_END       = 4;   // header bytes below this carry sequence digits
  localparam int TYPE_POS      = 4;
  localparam int LEN_END       = 9;   // length digits sit from TYPE_POS+1 up to just below this
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic        CHECK_CRC_RST  = 1'b1;
  localparam logic [15:0] MAX_LENGTH_RST = 16'd4096;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_PAY,
    PH_TRL
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TIMEOUT  = 3'd1,
    ST_SHORT    = 3'd2,
    ST_BAD_NUM  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_CRC_BAD  = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } cmd_t;

  typedef enum logic {
    CFG_CHECK_CRC  = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [15:0] seq;
    logic [7:0]  ftype;
    logic [15:0] length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = 4'(b - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/hhcr_front.sv]
// ----------------------------------------------------------------------------
// hhcr_front: frame parser
// Takes one word a cycle while the queue has space, tracks header, payload and
// trailer, runs the CRC and hex parsing, and queues payload and status results.
// ----------------------------------------------------------------------------
`default_nettype none

module hhcr_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_command,
  input  wire logic [7:0]       in_rx_byte,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             q_space,
  output logic                  q_push,
  output hhcr_pkg::result_t     q_data
);

  hhcr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt, pos_inc;
  logic [15:0] seq_r, seq_upd, seq_nxt;
  logic [15:0] len_r, len_upd, len_nxt;
  logic [7:0]  type_r, type_upd, type_nxt;
  logic        bad_seq_r, bad_seq_upd, bad_seq_nxt;
  logic        bad_len_r, bad_len_upd, bad_len_nxt;
  logic [31:0] crc_r, crc_upd, crc_nxt;
  logic [31:0] trl_r, trl_upd, trl_nxt;
  logic        bad_trl_r, bad_trl_upd, bad_trl_nxt;
  logic        check_crc_r;
  logic [15:0] max_len_r;

  hhcr_pkg::hex_t hex;
  logic acc, is_byte, hdr_last, hdr_bad, hdr_over, pay_last, trl_last, crc_bad, frame_end;

  assign in_ready = q_space;
  assign acc      = in_valid && q_space;
  assign is_byte  = (in_command == hhcr_pkg::CMD_BYTE);
  assign hex      = hhcr_pkg::hex_decode(in_rx_byte);
  assign pos_inc  = pos_r + 16'd1;

  // Digit accumulation and CRC for the current byte
  always_comb begin
    seq_upd     = seq_r;
    len_upd     = len_r;
    type_upd    = type_r;
    bad_seq_upd = bad_seq_r;
    bad_len_upd = bad_len_r;
    crc_upd     = crc_r;
    trl_upd     = trl_r;
    bad_trl_upd = bad_trl_r;
    if (is_byte) begin
      unique case (phase_r)
        hhcr_pkg::PH_HDR: begin
          crc_upd = hhcr_pkg::crc_update(crc_r, in_rx_byte);
          if (pos_r < 16'(hhcr_pkg::SEQ_END)) begin
            if (!hex.ok) begin
              bad_seq_upd = 1'b1;
            end else if (!bad_seq_r) begin
              seq_upd = {seq_r[11:0], hex.val};
            end
          end else if (pos_r == 16'(hhcr_pkg::TYPE_POS)) begin
            type_upd = in_rx_byte;
          end else if (pos_r < 16'(hhcr_pkg::LEN_END)) begin
            if (!hex.ok) begin
              bad_len_upd = 1'b1;
            end else if (!bad_len_r) begin
              len_upd = {len_r[11:0], hex.val};
            end
          end
        end
        hhcr_pkg::PH_PAY: begin
          crc_upd = hhcr_pkg::crc_update(crc_r, in_rx_byte);
        end
        hhcr_pkg::PH_TRL: begin
          if (!hex.ok) begin
            bad_trl_upd = 1'b1;
          end else if (!bad_trl_r) begin
            trl_upd = {trl_r[27:0], hex.val};
          end
        end
        default: ;
      endcase
    end
  end

  assign hdr_last = (phase_r == hhcr_pkg::PH_HDR) &&
                    (pos_r == 16'(hhcr_pkg::HEADER_BYTES - 1));
  assign hdr_bad  = bad_seq_upd || bad_len_upd;
  assign hdr_over = (len_upd > max_len_r);
  assign pay_last = (phase_r == hhcr_pkg::PH_PAY) && (pos_inc >= len_r);
  assign trl_last = (phase_r == hhcr_pkg::PH_TRL) &&
                    (pos_r == 16'(hhcr_pkg::TRAILER_BYTES - 1));
  assign crc_bad  = check_crc_r && (bad_trl_upd || (trl_upd != ~crc_r));

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (!is_byte) begin
        phase_nxt = hhcr_pkg::PH_HDR;
      end else begin
        unique case (phase_r)
          hhcr_pkg::PH_HDR: begin
            if (hdr_last) begin
              if (hdr_bad || hdr_over) begin
                phase_nxt = hhcr_pkg::PH_HDR;
              end else if (len_upd != 16'd0) begin
                phase_nxt = hhcr_pkg::PH_PAY;
              end else begin
                phase_nxt = hhcr_pkg::PH_TRL;
              end
            end
          end
          hhcr_pkg::PH_PAY: begin
            if (pay_last) phase_nxt = hhcr_pkg::PH_TRL;
          end
          hhcr_pkg::PH_TRL: begin
            if (trl_last) phase_nxt = hhcr_pkg::PH_HDR;
          end
          default: phase_nxt = hhcr_pkg::PH_HDR;
        endcase
      end
    end
  end

  // Result word and frame end
  always_comb begin
    q_push    = 1'b0;
    frame_end = 1'b0;
    q_data.kind         = hhcr_pkg::KIND_PAYLOAD;
    q_data.payload_byte = in_rx_byte;
    q_data.status       = hhcr_pkg::ST_OK;
    q_data.seq          = seq_r;
    q_data.ftype        = type_r;
    q_data.length       = len_r;
    if (acc) begin
      if (!is_byte) begin
        q_push              = 1'b1;
        frame_end           = 1'b1;
        q_data.kind         = hhcr_pkg::KIND_STATUS;
        q_data.payload_byte = 8'd0;
        q_data.status       = (pos_r == 16'd0) ? hhcr_pkg::ST_TIMEOUT : hhcr_pkg::ST_SHORT;
        if (phase_r == hhcr_pkg::PH_HDR) begin
          q_data.seq    = 16'd0;
          q_data.ftype  = 8'd0;
          q_data.length = 16'd0;
        end
      end else begin
        unique case (phase_r)
          hhcr_pkg::PH_HDR: begin
            if (hdr_last && (hdr_bad || hdr_over)) begin
              q_push              = 1'b1;
              frame_end           = 1'b1;
              q_data.kind         = hhcr_pkg::KIND_STATUS;
              q_data.payload_byte = 8'd0;
              q_data.status       = hdr_bad ? hhcr_pkg::ST_BAD_NUM : hhcr_pkg::ST_OVERFLOW;
              q_data.seq          = seq_upd;
              q_data.ftype        = type_upd;
              q_data.length       = len_upd;
            end
          end
          hhcr_pkg::PH_PAY: begin
            q_push = 1'b1;
          end
          hhcr_pkg::PH_TRL: begin
            if (trl_last) begin
              q_push              = 1'b1;
              frame_end           = 1'b1;
              q_data.kind         = hhcr_pkg::KIND_STATUS;
              q_data.payload_byte = 8'd0;
              q_data.status       = crc_bad ? hhcr_pkg::ST_CRC_BAD : hhcr_pkg::ST_OK;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Drop all frame state at a frame end, otherwise take the updated values
  always_comb begin
    if (frame_end) begin
      pos_nxt     = 16'd0;
      seq_nxt     = 16'd0;
      len_nxt     = 16'd0;
      type_nxt    = 8'd0;
      bad_seq_nxt = 1'b0;
      bad_len_nxt = 1'b0;
      crc_nxt     = hhcr_pkg::CRC_INIT;
      trl_nxt     = 32'd0;
      bad_trl_nxt = 1'b0;
    end else begin
      pos_nxt     = (hdr_last || pay_last) ? 16'd0 : pos_inc;
      seq_nxt     = seq_upd;
      len_nxt     = len_upd;
      type_nxt    = type_upd;
      bad_seq_nxt = bad_seq_upd;
      bad_len_nxt = bad_len_upd;
      crc_nxt     = crc_upd;
      trl_nxt     = trl_upd;
      bad_trl_nxt = bad_trl_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= hhcr_pkg::PH_HDR;
      pos_r     <= 16'd0;
      seq_r     <= 16'd0;
      len_r     <= 16'd0;
      type_r    <= 8'd0;
      bad_seq_r <= 1'b0;
      bad_len_r <= 1'b0;
      crc_r     <= hhcr_pkg::CRC_INIT;
      trl_r     <= 32'd0;
      bad_trl_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (acc) begin
        pos_r     <= pos_nxt;
        seq_r     <= seq_nxt;
        len_r     <= len_nxt;
        type_r    <= type_nxt;
        bad_seq_r <= bad_seq_nxt;
        bad_len_r <= bad_len_nxt;
        crc_r     <= crc_nxt;
        trl_r     <= trl_nxt;
        bad_trl_r <= bad_trl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_crc_r <= hhcr_pkg::CHECK_CRC_RST;
      max_len_r   <= hhcr_pkg::MAX_LENGTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hhcr_pkg::CFG_CHECK_CRC:  check_crc_r <= cfg_data[0];
        hhcr_pkg::CFG_MAX_LENGTH: max_len_r   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/hhcr_queue.sv]
// ----------------------------------------------------------------------------
// hhcr_queue: result queue
// Small circular buffer of result words between the parser and the output
// stage, so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module hhcr_queue #(
  parameter int DEPTH = hhcr_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hhcr_pkg::result_t push_data,
  output logic                   space,
  input  wire logic              pop,
  output logic                   head_valid,
  output hhcr_pkg::result_t      head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hhcr_pkg::result_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign space      = (cnt_r != CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && space;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/hhcr_back.sv]
// ----------------------------------------------------------------------------
// hhcr_back: output stage
// Pulls result words from the queue into the output register and holds
// them until the consumer takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module hhcr_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire hhcr_pkg::result_t head_data,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_result_kind,
  output logic [7:0]             out_payload_byte,
  output logic [2:0]             out_status,
  output logic [15:0]            out_frame_seq,
  output logic [7:0]             out_frame_type,
  output logic [15:0]            out_frame_length
);

  logic              out_valid_r, out_valid_nxt;
  hhcr_pkg::result_t out_data_r;
  logic              load;

  // Advance when the register is empty or its word leaves this cycle
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= head_data;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_data_r.kind;
  assign out_payload_byte = out_data_r.payload_byte;
  assign out_status       = out_data_r.status;
  assign out_frame_seq    = out_data_r.seq;
  assign out_frame_type   = out_data_r.ftype;
  assign out_frame_length = out_data_r.length;

endmodule

`default_nettype wire

[rtl/core/hex_header_crc_frame_receiver.sv]
// ----------------------------------------------------------------------------
// hex_header_crc_frame_receiver: byte-serial frame receiver with CRC-32 check
//
// Input channel (in_*): one word per received byte (in_command = 0) or a
// receive timeout event (in_command = 1). A frame is a 10-byte header
// (4 hex sequence digits, type byte, 4 hex length digits, one spare byte),
// the payload, and 8 hex digits of CRC-32 over header and payload.
// Output channel (out_*): one word per payload byte, and one status word at
// every frame end (ok, timeout, short receive, bad number, overflow, CRC
// mismatch). Header failures end the frame as soon as the header completes.
// Config channel (cfg_*): index 0 enables the CRC check, index 1 sets the
// largest accepted payload length. Always ready; write only while idle.
// Throughput: one input word per cycle while in_ready is high, with the byte
// CRC update and digit parse done combinationally in the front parser. A result
// reaches out_* through the queue register, then the output register.
// When out_ready is low, the queue fills and in_ready drops after
// QUEUE_DEPTH more results; nothing is lost.
// Reset (rst_n low, synchronous) clears the frame state, empties the queue
// and restores the configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_header_crc_frame_receiver #(
  parameter int QUEUE_DEPTH = hhcr_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic [2:0]       out_status,
  output logic [15:0]      out_frame_seq,
  output logic [7:0]       out_frame_type,
  output logic [15:0]      out_frame_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic              q_push, q_space, q_pop, q_head_valid;
  hhcr_pkg::result_t q_data, q_head_data;

  assign cfg_ready = 1'b1;

  hhcr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_rx_byte (in_rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_space    (q_space),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  hhcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .space      (q_space),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  hhcr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_data        (q_head_data),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_status       (out_status),
    .out_frame_seq    (out_frame_seq),
    .out_frame_type   (out_frame_type),
    .out_frame_length (out_frame_length)
  );

endmodule

`default_nettype wire

[rtl/core/hhcr_prop_chk.sv]
// ----------------------------------------------------------------------------
// hhcr_prop_chk: port-level checks for the frame receiver
// Watches the top-level ports and flags result words that break the output
// handshake or carry field combinations the receiver never produces.
// ----------------------------------------------------------------------------
`default_nettype none

module hhcr_prop_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_result_kind,
  input wire logic [7:0]  out_payload_byte,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_frame_seq,
  input wire logic [7:0]  out_frame_type,
  input wire logic [15:0] out_frame_length
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_payload_byte) && $stable(out_status)
      && $stable(out_frame_seq) && $stable(out_frame_type) && $stable(out_frame_length))
    else $error("result word changed while stalled");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == hhcr_pkg::KIND_STATUS) |->
      out_payload_byte == 8'd0 && out_status <= hhcr_pkg::ST_CRC_BAD)
    else $error("status word with payload bits or unknown code");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == hhcr_pkg::KIND_PAYLOAD) |->
      out_status == hhcr_pkg::ST_OK && out_frame_length != 16'd0)
    else $error("payload word with status code or zero length");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind hex_header_crc_frame_receiver hhcr_prop_chk u_prop_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_kind  (out_result_kind),
  .out_payload_byte (out_payload_byte),
  .out_status       (out_status),
  .out_frame_seq    (out_frame_seq),
  .out_frame_type   (out_frame_type),
  .out_frame_length (out_frame_length)
);

`default_nettype wire
